>>> sv/bads_pkg.sv
// ----------------------------------------------------------------------------
// bads_pkg
// Shared types and constants of the block average downsampler: register
// indexes, fixed field widths, controller states and control structs.
// ----------------------------------------------------------------------------
package bads_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;
    localparam int STRIDE_BITS    = 4;
    localparam int DIM_BITS       = 11;
    localparam int MAX_HEIGHT     = 1024;
    localparam int ROW_BITS       = 10;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE_X    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE_Y    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARSE_MODE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_START,
        ST_COL_WAIT,
        ST_MEM_RD,
        ST_UPDATE,
        ST_SUM_START,
        ST_SUM_WAIT,
        ST_EMIT
    } bads_state_t;

    typedef struct packed {
        logic in_ready;
        logic load_item;
        logic col_div_start;
        logic col_capture;
        logic mem_read;
        logic update;
        logic sum_div_start;
        logic sum_capture;
        logic emit;
    } bads_cmd_t;

    typedef struct packed {
        logic div_done;
        logic bottom_right;
        logic sparse;
        logic out_free;
    } bads_status_t;

endpackage

>>> sv/block_average_downsample.sv
// ----------------------------------------------------------------------------
// block_average_downsample
// Non-overlapping block reduction of an upsampled gradient stream: averages
// (or keeps the top-left sample of) each stride_x by stride_y block.
// ----------------------------------------------------------------------------
// One item at a time: a new item is accepted only once the previous one has
//   passed the bit-serial divider that maps its column to its accumulator, which
//   is D = max(column counter bits, SAMPLE_BITS + 6) = 22 bits wide at the defaults.
// An averaging block's last item then runs the block divide on the same divider
//   and loads the output register; a sparse block's last item only loads the
//   output register, which is held while the output is full.
// Reset clears counters, controller and output valid; registers return to
//   their defaults; accumulators are undefined until written (no clear pass).
module block_average_downsample
    import bads_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_STRIDE  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [SAMPLE_BITS-1:0] sample, upper bits zero
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // last_sample
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [SAMPLE_BITS-1:0] value, upper bits zero
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // [0] end_of_row, [1] end_of_plane
    output logic [1:0]                    m_axis_tuser,
    // end_of_data
    output logic                          m_axis_tlast
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    bads_cmd_t                     cmd;
    bads_status_t                  status;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          end_of_row, end_of_plane;

    bads_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    bads_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_STRIDE  (MAX_STRIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .last_sample  (s_axis_tlast),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .value        (value),
        .end_of_row   (end_of_row),
        .end_of_plane (end_of_plane),
        .end_of_data  (m_axis_tlast)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = cmd.in_ready;
    assign m_axis_tdata  = TDATA_BITS'($unsigned(value));
    assign m_axis_tuser  = {end_of_plane, end_of_row};

endmodule

>>> sv/bads_divider.sv
// ----------------------------------------------------------------------------
// bads_divider
// Restoring unsigned divider, one quotient bit per cycle. Operands are
// latched on start; done pulses for one cycle when the results are ready.
// ----------------------------------------------------------------------------
module bads_divider #(
    parameter int DW = 22,
    parameter int PW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [PW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic [PW-1:0] remainder,
    output logic          done
);

    localparam int CNW = $clog2(DW + 1);

    logic [DW-1:0]  quo_reg, quo_next;
    logic [PW-1:0]  rem_reg, rem_next;
    logic [PW-1:0]  dvs_reg;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [PW:0]    trial;
    logic [PW:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNW'(DW);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[PW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNW'(1);
            done_next = (cnt_reg == CNW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

>>> sv/bads_ctrl.sv
// ----------------------------------------------------------------------------
// bads_ctrl
// Controller of the block average downsampler: steps each item through
// column divide and accumulator read-modify-write and, at a block's last
// item, the block divide (average mode only) and result emission.
// ----------------------------------------------------------------------------
module bads_ctrl
    import bads_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  bads_status_t status,
    output bads_cmd_t    cmd
);

    bads_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_COL_START;
                end
            end
            ST_COL_START: state_next = ST_COL_WAIT;
            ST_COL_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_MEM_RD;
                end
            end
            ST_MEM_RD: state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (!status.bottom_right)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.sparse)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SUM_START;
                end
            end
            ST_SUM_START: state_next = ST_SUM_WAIT;
            ST_SUM_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready  = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_COL_START: cmd.col_div_start = 1'b1;
            ST_COL_WAIT:  cmd.col_capture   = status.div_done;
            ST_MEM_RD:    cmd.mem_read      = 1'b1;
            ST_UPDATE:    cmd.update        = 1'b1;
            ST_SUM_START: cmd.sum_div_start = 1'b1;
            ST_SUM_WAIT:  cmd.sum_capture   = status.div_done;
            ST_EMIT:      cmd.emit          = status.out_free;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/bads_datapath.sv
// ----------------------------------------------------------------------------
// bads_datapath
// Configuration registers, position counters, column accumulator memory,
// shared divider and the output register of the block average downsampler.
// ----------------------------------------------------------------------------
module bads_datapath
    import bads_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_STRIDE  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last_sample,
    input  bads_cmd_t                     cmd,
    output bads_status_t                  status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] value,
    output logic                          end_of_row,
    output logic                          end_of_plane,
    output logic                          end_of_data
);

    localparam int SUM_BITS = SAMPLE_BITS + 6;
    localparam int SXW      = $clog2(MAX_STRIDE + 1);
    localparam int PW       = $clog2(MAX_STRIDE * MAX_STRIDE + 1);
    localparam int LWW      = $clog2(MAX_WIDTH + 1);
    localparam int XW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW       = $clog2(MAX_WIDTH * MAX_STRIDE + 1);
    localparam int DW       = (CW > SUM_BITS) ? CW : SUM_BITS;
    localparam logic signed [SUM_BITS-1:0] SAT_HI =
        SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);

    // configuration
    logic [STRIDE_BITS-1:0] stride_x_reg, stride_y_reg;
    logic [DIM_BITS-1:0]    low_width_reg, low_height_reg;
    logic                   sparse_mode_reg;

    logic [SXW-1:0]      sx, sy;
    logic [LWW-1:0]      lw;
    logic [DIM_BITS-1:0] lh;
    logic [CW-1:0]       span;
    logic [PW-1:0]       block_size;

    // item and position state
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;
    logic [CW-1:0]                 col_reg, col_next;
    logic [SXW-1:0]                phase_reg, phase_next;
    logic [ROW_BITS-1:0]           row_reg, row_next;
    logic [XW-1:0]                 lowx_reg;
    logic [SXW-1:0]                px_reg;
    logic                          top_left_reg, bottom_right_reg;
    logic                          row_end_reg, plane_end_reg;

    // accumulator memory
    logic signed [SUM_BITS-1:0] mem [MAX_WIDTH];
    logic signed [SUM_BITS-1:0] rd_data_reg;
    logic signed [SUM_BITS-1:0] new_sum;
    logic                       mem_wr;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic                       neg_reg;
    logic [SUM_BITS-1:0]        sum_mag;

    // divider
    logic          div_start;
    logic [DW-1:0] div_dividend, div_quotient;
    logic [PW-1:0] div_divisor, div_remainder;
    logic          div_done;
    logic signed [SUM_BITS-1:0] quo_signed;

    // output
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic                          eor_reg, eop_reg, eod_reg;
    logic signed [SAMPLE_BITS-1:0] sat_value;

    // effective configuration: clamp out-of-range register values
    always_comb
    begin
        if (stride_x_reg == '0)
            sx = SXW'(1);
        else if (32'(stride_x_reg) > MAX_STRIDE)
            sx = SXW'(MAX_STRIDE);
        else
            sx = SXW'(stride_x_reg);

        if (stride_y_reg == '0)
            sy = SXW'(1);
        else if (32'(stride_y_reg) > MAX_STRIDE)
            sy = SXW'(MAX_STRIDE);
        else
            sy = SXW'(stride_y_reg);

        if (low_width_reg == '0)
            lw = LWW'(1);
        else if (32'(low_width_reg) > MAX_WIDTH)
            lw = LWW'(MAX_WIDTH);
        else
            lw = LWW'(low_width_reg);

        if (low_height_reg == '0)
            lh = DIM_BITS'(1);
        else if (32'(low_height_reg) > MAX_HEIGHT)
            lh = DIM_BITS'(MAX_HEIGHT);
        else
            lh = low_height_reg;
    end

    assign span       = CW'(lw) * CW'(sx);
    assign block_size = PW'(sx) * PW'(sy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_x_reg    <= STRIDE_BITS'(2);
            stride_y_reg    <= STRIDE_BITS'(2);
            low_width_reg   <= DIM_BITS'(1024);
            low_height_reg  <= DIM_BITS'(1024);
            sparse_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STRIDE_X:    stride_x_reg    <= cfg_data[STRIDE_BITS-1:0];
                REG_STRIDE_Y:    stride_y_reg    <= cfg_data[STRIDE_BITS-1:0];
                REG_LOW_WIDTH:   low_width_reg   <= cfg_data;
                REG_LOW_HEIGHT:  low_height_reg  <= cfg_data;
                REG_SPARSE_MODE: sparse_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // position counters: wrap on load, advance after the accumulator update (clear on a last sample)
    always_comb
    begin
        col_next   = col_reg;
        phase_next = phase_reg;
        row_next   = row_reg;
        if (cmd.load_item)
        begin
            if (col_reg >= span)
                col_next = '0;
            if (phase_reg >= sy)
                phase_next = '0;
            if (DIM_BITS'(row_reg) >= lh)
                row_next = '0;
        end
        else if (cmd.update)
        begin
            if (last_reg)
            begin
                col_next   = '0;
                phase_next = '0;
                row_next   = '0;
            end
            else if ({1'b0, col_reg} + (CW + 1)'(1) >= {1'b0, span})
            begin
                col_next = '0;
                if ({1'b0, phase_reg} + (SXW + 1)'(1) >= {1'b0, sy})
                begin
                    phase_next = '0;
                    if (DIM_BITS'(row_reg) + DIM_BITS'(1) >= lh)
                        row_next = '0;
                    else
                        row_next = row_reg + ROW_BITS'(1);
                end
                else
                begin
                    phase_next = phase_reg + SXW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            phase_reg <= '0;
            row_reg   <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            phase_reg <= phase_next;
            row_reg   <= row_next;
        end
    end

    // shared divider: column by stride_x, then block sum by block size
    assign sum_mag      = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);
    assign div_start    = cmd.col_div_start | cmd.sum_div_start;
    assign div_dividend = cmd.sum_div_start ? DW'(sum_mag) : DW'(col_reg);
    assign div_divisor  = cmd.sum_div_start ? block_size : PW'(sx);

    bads_divider #(
        .DW (DW),
        .PW (PW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .done      (div_done)
    );

    assign quo_signed = neg_reg ? -$signed(div_quotient[SUM_BITS-1:0])
                                : $signed(div_quotient[SUM_BITS-1:0]);

    // top-left overwrites, the rest of the block adds in average mode
    assign new_sum = top_left_reg ? SUM_BITS'(sample_reg) : rd_data_reg + SUM_BITS'(sample_reg);
    assign mem_wr  = cmd.update & (top_left_reg | ~sparse_mode_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[lowx_reg];
        end
        if (mem_wr)
        begin
            mem[lowx_reg] <= new_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            sample_reg <= sample;
            last_reg   <= last_sample;
        end
        if (cmd.col_capture)
        begin
            lowx_reg <= div_quotient[XW-1:0];
            px_reg   <= div_remainder[SXW-1:0];
        end
        if (cmd.mem_read)
        begin
            top_left_reg     <= (phase_reg == '0) && (px_reg == '0);
            bottom_right_reg <= (phase_reg == sy - SXW'(1)) && (px_reg == sx - SXW'(1));
            row_end_reg      <= (LWW'(lowx_reg) == lw - LWW'(1));
            plane_end_reg    <= (LWW'(lowx_reg) == lw - LWW'(1)) &&
                                (DIM_BITS'(row_reg) == lh - DIM_BITS'(1));
        end
        if (cmd.update)
        begin
            sum_reg <= mem_wr ? new_sum : rd_data_reg;
        end
        else if (cmd.sum_capture)
        begin
            sum_reg <= quo_signed;
        end
        if (cmd.sum_div_start)
        begin
            neg_reg <= sum_reg[SUM_BITS-1];
        end
    end

    // saturate to the sample range and hold the result until taken
    always_comb
    begin
        if (sum_reg > SAT_HI)
            sat_value = SAT_HI[SAMPLE_BITS-1:0];
        else if (sum_reg < SAT_LO)
            sat_value = SAT_LO[SAMPLE_BITS-1:0];
        else
            sat_value = sum_reg[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            value_reg <= sat_value;
            eor_reg   <= row_end_reg;
            eop_reg   <= plane_end_reg;
            eod_reg   <= last_reg;
        end
    end

    assign status.div_done     = div_done;
    assign status.bottom_right = bottom_right_reg;
    assign status.sparse       = sparse_mode_reg;
    assign status.out_free     = ~out_valid_reg | out_ready;

    assign out_valid    = out_valid_reg;
    assign value        = value_reg;
    assign end_of_row   = eor_reg;
    assign end_of_plane = eop_reg;
    assign end_of_data  = eod_reg;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream test of block_average_downsample. Upsampled samples are sent in
// raster order under several register settings; a model of the block
// reduction computes each expected value and its row, plane and data
// markers, and every output item is compared against it in order. Both
// stream sides idle at random, with one long stretch held busy.
// ----------------------------------------------------------------------------
module tb
    import bads_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_STRIDE   = 8;
    localparam int SUM_BITS     = SAMPLE_BITS + 6;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 200;
    localparam int PHASE_CAP    = 64;
    localparam int IDLE_PERCENT = 14;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          end_of_row;
        logic                          end_of_plane;
        logic                          end_of_data;
    } reduced_t;

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         cfg_valid     = 1'b0;
    logic                         cfg_ready;
    logic [CFG_INDEX_BITS-1:0]    cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_data      = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [SAMPLE_BITS-1:0]       s_axis_tdata  = '0;
    logic                         s_axis_tlast  = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b1;
    logic [SAMPLE_BITS-1:0]       m_axis_tdata;
    logic [1:0]                   m_axis_tuser;
    logic                         m_axis_tlast;

    logic no_idle     = 1'b0;
    int   error_count = 0;

    // shadow registers and counters of the block
    logic [STRIDE_BITS-1:0]     shadow_stride_x   = 4'd2;
    logic [STRIDE_BITS-1:0]     shadow_stride_y   = 4'd2;
    logic [DIM_BITS-1:0]        shadow_low_width  = 11'd1024;
    logic [DIM_BITS-1:0]        shadow_low_height = 11'd1024;
    logic                       shadow_sparse     = 1'b0;
    logic signed [SUM_BITS-1:0] column_acc [MAX_WIDTH];
    int                         up_column = 0;
    int                         block_row = 0;
    int                         low_row   = 0;

    reduced_t expected_blocks [$];

    block_average_downsample #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_STRIDE  (MAX_STRIDE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    function automatic int clamp_int(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Advance the block model by one accepted sample.
    task automatic reduce_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
        int       sx;
        int       sy;
        int       lw;
        int       lh;
        int       lowx;
        int       px;
        int       v;
        logic     top_left;
        logic     bottom_right;
        logic     row_end;
        reduced_t res;
        sx = clamp_int(int'(shadow_stride_x), 1, MAX_STRIDE);
        sy = clamp_int(int'(shadow_stride_y), 1, MAX_STRIDE);
        lw = clamp_int(int'(shadow_low_width), 1, MAX_WIDTH);
        lh = clamp_int(int'(shadow_low_height), 1, MAX_HEIGHT);
        if (up_column >= lw * sx) up_column = 0;
        if (block_row >= sy) block_row = 0;
        if (low_row >= lh) low_row = 0;
        lowx = up_column / sx;
        px   = up_column % sx;
        if (lowx >= MAX_WIDTH) lowx = MAX_WIDTH - 1;
        top_left     = (block_row == 0) && (px == 0);
        bottom_right = (block_row == sy - 1) && (px == sx - 1);
        row_end      = (lowx == lw - 1);
        // the top-left sample starts the block and overwrites the accumulator
        if (top_left)
            column_acc[lowx] = smp;
        else if (!shadow_sparse)
            column_acc[lowx] = column_acc[lowx] + smp;
        if (bottom_right)
        begin
            v = column_acc[lowx];
            if (!shadow_sparse) v = v / (sx * sy);
            v = clamp_int(v, int'(SAMPLE_MIN), int'(SAMPLE_MAX));
            res.value        = v[SAMPLE_BITS-1:0];
            res.end_of_row   = row_end;
            res.end_of_plane = row_end && (low_row == lh - 1);
            res.end_of_data  = last;
            expected_blocks.push_back(res);
        end
        if (last)
        begin
            up_column = 0;
            block_row = 0;
            low_row   = 0;
        end
        else if (up_column + 1 >= lw * sx)
        begin
            up_column = 0;
            block_row++;
            if (block_row >= sy)
            begin
                block_row = 0;
                low_row++;
                if (low_row >= lh) low_row = 0;
            end
        end
        else
        begin
            up_column++;
        end
    endtask

    // Hold tvalid high across back-to-back items; drop it only for idle cycles.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic last);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        reduce_sample(smp, last);
    endtask

    // Wait until every expected value is out and the block has gone quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_STRIDE_X:    shadow_stride_x   = data[STRIDE_BITS-1:0];
            REG_STRIDE_Y:    shadow_stride_y   = data[STRIDE_BITS-1:0];
            REG_LOW_WIDTH:   shadow_low_width  = data[DIM_BITS-1:0];
            REG_LOW_HEIGHT:  shadow_low_height = data[DIM_BITS-1:0];
            REG_SPARSE_MODE: shadow_sparse     = data[0];
            default: ;
        endcase
    endtask

    task automatic load_registers(input logic [CFG_DATA_BITS-1:0] sx,
                                  input logic [CFG_DATA_BITS-1:0] sy,
                                  input logic [CFG_DATA_BITS-1:0] lw,
                                  input logic [CFG_DATA_BITS-1:0] lh,
                                  input logic [CFG_DATA_BITS-1:0] sparse);
        settle();
        write_reg(REG_STRIDE_X, sx);
        write_reg(REG_STRIDE_Y, sy);
        write_reg(REG_LOW_WIDTH, lw);
        write_reg(REG_LOW_HEIGHT, lh);
        write_reg(REG_SPARSE_MODE, sparse);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_BITS'($signed($urandom_range(0, 15)) - 8);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin : check_values
        reduced_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_blocks.size() == 0)
            begin
                report_mismatch("unexpected value", $signed(m_axis_tdata), 0);
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (m_axis_tdata !== want.value)
                    report_mismatch("value", $signed(m_axis_tdata), want.value);
                if (m_axis_tuser[0] !== want.end_of_row)
                    report_mismatch("end_of_row", int'(m_axis_tuser[0]),
                                    int'(want.end_of_row));
                if (m_axis_tuser[1] !== want.end_of_plane)
                    report_mismatch("end_of_plane", int'(m_axis_tuser[1]),
                                    int'(want.end_of_plane));
                if (m_axis_tlast !== want.end_of_data)
                    report_mismatch("end_of_data", int'(m_axis_tlast),
                                    int'(want.end_of_data));
            end
        end
    end

    // Reset registers, then a last_sample before any block completes.
    task automatic test_default_registers();
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd5, 1'b1);
    endtask

    // Full-scale blocks and rounding toward zero in average mode.
    task automatic test_average_extremes();
        load_registers(11'd2, 11'd2, 11'd1, 11'd1, 11'd0);
        repeat (4) send_sample(SAMPLE_MAX, 1'b0);
        repeat (4) send_sample(SAMPLE_MIN, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b1);
    endtask

    task automatic test_sparse_top_left();
        load_registers(11'd2, 11'd1, 11'd2, 11'd1, 11'd1);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd5, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
    endtask

    // Strides and sizes outside the legal range, and unused register indexes.
    task automatic test_clamped_registers();
        load_registers(11'd15, 11'd0, 11'd0, 11'd0, 11'd0);
        for (int idx = REG_SPARSE_MODE + 1; idx < (1 << CFG_INDEX_BITS); idx++)
            write_reg(idx[CFG_INDEX_BITS-1:0], CFG_DATA_BITS'($urandom));
        cfg_valid <= 1'b0;
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd3, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd9, 1'b0);
        send_sample(16'sd2, 1'b1);
    endtask

    // One full row at the widest setting, both sides held busy.
    task automatic test_wide_row();
        load_registers(11'd1, 11'd1, 11'd2047, 11'd1, 11'($urandom_range(0, 1)));
        no_idle = 1'b1;
        for (int i = 0; i < MAX_WIDTH; i++)
            send_sample(pick_sample(), i == MAX_WIDTH - 1);
        settle();
        no_idle = 1'b0;
    endtask

    task automatic test_random_planes();
        int   sent;
        int   plane;
        int   count;
        logic well_formed;
        logic [CFG_DATA_BITS-1:0] sx;
        logic [CFG_DATA_BITS-1:0] sy;
        logic [CFG_DATA_BITS-1:0] lw;
        logic [CFG_DATA_BITS-1:0] lh;
        logic [CFG_DATA_BITS-1:0] sparse;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            sx = CFG_DATA_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(1, 8));
            sy = CFG_DATA_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                            : $urandom_range(1, 8));
            lw = CFG_DATA_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                            : $urandom_range(1, 5));
            lh = CFG_DATA_BITS'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                                            : $urandom_range(1, 3));
            sparse = CFG_DATA_BITS'($urandom_range(0, 1));
            plane = clamp_int(int'(sx[STRIDE_BITS-1:0]), 1, MAX_STRIDE)
                  * clamp_int(int'(sy[STRIDE_BITS-1:0]), 1, MAX_STRIDE)
                  * clamp_int(int'(lw), 1, MAX_WIDTH) * clamp_int(int'(lh), 1, MAX_HEIGHT);
            // junk above the field width must be ignored
            if ($urandom_range(0, 3) == 0)
                sx[CFG_DATA_BITS-1:STRIDE_BITS] = (CFG_DATA_BITS - STRIDE_BITS)'($urandom);
            if ($urandom_range(0, 3) == 0)
                sy[CFG_DATA_BITS-1:STRIDE_BITS] = (CFG_DATA_BITS - STRIDE_BITS)'($urandom);
            if ($urandom_range(0, 3) == 0)
                sparse[CFG_DATA_BITS-1:1] = (CFG_DATA_BITS - 1)'($urandom);
            load_registers(sx, sy, lw, lh, sparse);
            well_formed = $urandom_range(0, 99) < 80;
            if (well_formed)
                count = clamp_int(plane * int'($urandom_range(1, 2)), 1, PHASE_CAP);
            else
                count = int'($urandom_range(1, clamp_int(plane * 2, 1, PHASE_CAP)));
            for (int i = 0; i < count; i++)
                send_sample(pick_sample(),
                            (i == count - 1) || (!well_formed && $urandom_range(0, 15) == 0));
            sent += count;
        end
    endtask

    initial
    begin
        foreach (column_acc[i]) column_acc[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_registers();
        test_average_extremes();
        test_sparse_top_left();
        test_clamped_registers();
        test_random_planes();
        test_wide_row();
        settle();
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
